FILE: sv/mest_pkg.sv
package mest_pkg;

  localparam int unsigned TABLE_SIZE = 128;
  localparam int unsigned KEY_W      = 7;
  localparam logic [6:0]  MAX7       = 7'd127;
  localparam logic [13:0] BEND_CENTER = 14'd8192;

  typedef enum logic [3:0] {
    CMD_FRAME    = 4'd0,
    CMD_NOTE_ON  = 4'd1,
    CMD_NOTE_OFF = 4'd2,
    CMD_CTRL     = 4'd3,
    CMD_BEND     = 4'd4,
    CMD_RD_VEL   = 4'd5,
    CMD_RD_CTRL  = 4'd6,
    CMD_RD_SLOT  = 4'd7,
    CMD_CLEAR    = 4'd8
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SHIFT,
    ST_RDWAIT,
    ST_DONE
  } state_t;

  function automatic logic [6:0] sat7(input logic [13:0] v);
    return (v > 14'(MAX7)) ? MAX7 : v[6:0];
  endfunction

endpackage

FILE: sv/midi_event_state_tracker.sv
// MIDI event tracker: one result transaction per input transaction, in order. The block
// takes an event only when it is idle and holds it until the result is loaded into the
// output register, which may still be waiting on out_ready while the next event comes in.
// Frame start, controller, pitch bend, clear and unused commands go from idle straight
// to the done state, reads pass a read-wait state first. Note-on and note-off walk the
// held-note list in its memory (one read port, one write port) one entry a cycle, and a
// note-off that removes an entry then moves the later entries down a slot. Velocity and
// controller tables reset through per-entry valid bits, so reset and clear take effect
// at once with no clearing pass.
module midi_event_state_tracker #(
  parameter int unsigned LIST_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_cmd,
  input  logic [7:0]         in_number,
  input  logic [13:0]        in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         out_read_value,
  output logic [7:0]         out_held_count,
  output logic               out_any_note_flag,
  output logic signed [13:0] out_bend_offset
);
  import mest_pkg::*;

  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  state_t state_r, state_nxt;

  logic [CW-1:0]         count_r, count_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic                  pend_r, pend_nxt;
  logic [13:0]           bend_r, bend_nxt;
  logic                  flag_r, flag_nxt;
  logic [TABLE_SIZE-1:0] vel_vld_r, vel_vld_nxt;
  logic [TABLE_SIZE-1:0] ctl_vld_r, ctl_vld_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [KEY_W-1:0]      num_r, num_nxt;
  logic                  ok_r, ok_nxt;
  logic                  slot_ok_r, slot_ok_nxt;
  logic [6:0]            rd_r, rd_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [6:0]            out_rd_r, out_rd_nxt;
  logic [7:0]            out_cnt_r, out_cnt_nxt;
  logic                  out_flag_r, out_flag_nxt;
  logic [13:0]           out_bend_r, out_bend_nxt;

  // note and controller tables
  logic [6:0] vel_mem [TABLE_SIZE];
  logic [6:0] ctl_mem [TABLE_SIZE];
  logic [6:0] vel_q, ctl_q;
  logic       vel_we, ctl_we;

  // held-note list
  logic [6:0]    held_mem [LIST_DEPTH];
  logic [6:0]    held_q;
  logic          held_we;
  logic [AW-1:0] held_wa, held_ra;
  logic [6:0]    held_wd;

  logic          acc;
  logic          hit;
  logic          at_end;
  logic          in_ok;
  logic [CW-1:0] shift_wa;
  logic          out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign acc       = in_valid & in_ready;
  assign in_ok     = ~in_number[7];
  assign hit       = pend_r && (held_q == num_r);
  assign at_end    = (idx_r >= count_r);
  assign shift_wa  = idx_r - CW'(2);
  assign out_free  = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (cmd_t'(in_cmd))
            CMD_NOTE_ON, CMD_NOTE_OFF: state_nxt = in_ok ? ST_SEARCH : ST_DONE;
            CMD_RD_VEL, CMD_RD_CTRL, CMD_RD_SLOT: state_nxt = ST_RDWAIT;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          state_nxt = (cmd_r == CMD_NOTE_OFF) ? ST_SHIFT : ST_DONE;
        end else if (at_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT: begin
        if (at_end && !pend_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RDWAIT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    bend_nxt      = bend_r;
    flag_nxt      = flag_r;
    vel_vld_nxt   = vel_vld_r;
    ctl_vld_nxt   = ctl_vld_r;
    cmd_nxt       = cmd_r;
    num_nxt       = num_r;
    ok_nxt        = ok_r;
    slot_ok_nxt   = slot_ok_r;
    rd_nxt        = rd_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_rd_nxt    = out_rd_r;
    out_cnt_nxt   = out_cnt_r;
    out_flag_nxt  = out_flag_r;
    out_bend_nxt  = out_bend_r;
    vel_we        = 1'b0;
    ctl_we        = 1'b0;
    held_we       = 1'b0;
    held_wa       = '0;
    held_wd       = '0;
    held_ra       = idx_r[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        held_ra = in_number[AW-1:0];
        if (acc) begin
          cmd_nxt     = cmd_t'(in_cmd);
          num_nxt     = in_number[KEY_W-1:0];
          ok_nxt      = in_ok;
          slot_ok_nxt = (in_number < 8'(count_r));
          rd_nxt      = '0;
          idx_nxt     = '0;
          pend_nxt    = 1'b0;
          case (cmd_t'(in_cmd))
            CMD_FRAME: flag_nxt = 1'b0;
            CMD_NOTE_ON: begin
              if (in_ok) begin
                vel_we                          = 1'b1;
                vel_vld_nxt[in_number[KEY_W-1:0]] = 1'b1;
                flag_nxt                        = 1'b1;
              end
            end
            CMD_NOTE_OFF: begin
              if (in_ok) begin
                vel_vld_nxt[in_number[KEY_W-1:0]] = 1'b0;
              end
            end
            CMD_CTRL: begin
              if (in_ok) begin
                ctl_we                          = 1'b1;
                ctl_vld_nxt[in_number[KEY_W-1:0]] = 1'b1;
              end
            end
            CMD_BEND: bend_nxt = in_value - BEND_CENTER;
            CMD_CLEAR: begin
              vel_vld_nxt = '0;
              ctl_vld_nxt = '0;
              count_nxt   = '0;
              bend_nxt    = '0;
              flag_nxt    = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SEARCH: begin
        // compare uses the registered read issued in the previous cycle
        if (hit) begin
          pend_nxt = 1'b0;
        end else if (at_end) begin
          pend_nxt = 1'b0;
          if (cmd_r == CMD_NOTE_ON && count_r < CW'(LIST_DEPTH)) begin
            held_we   = 1'b1;
            held_wa   = count_r[AW-1:0];
            held_wd   = num_r;
            count_nxt = count_r + CW'(1);
          end
        end else begin
          held_ra  = idx_r[AW-1:0];
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end
      end
      ST_SHIFT: begin
        // read slot idx, write it back one slot lower in the following cycle
        if (pend_r) begin
          held_we = 1'b1;
          held_wa = shift_wa[AW-1:0];
          held_wd = held_q;
        end
        if (!at_end) begin
          held_ra  = idx_r[AW-1:0];
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - CW'(1);
          end
        end
      end
      ST_RDWAIT: begin
        case (cmd_r)
          CMD_RD_VEL:  rd_nxt = (ok_r && vel_vld_r[num_r]) ? vel_q : '0;
          CMD_RD_CTRL: rd_nxt = (ok_r && ctl_vld_r[num_r]) ? ctl_q : '0;
          CMD_RD_SLOT: rd_nxt = slot_ok_r ? held_q : '0;
          default:     rd_nxt = '0;
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = rd_r;
          out_cnt_nxt   = 8'(count_r);
          out_flag_nxt  = flag_r;
          out_bend_nxt  = bend_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      bend_r      <= '0;
      flag_r      <= 1'b0;
      vel_vld_r   <= '0;
      ctl_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      bend_r      <= bend_nxt;
      flag_r      <= flag_nxt;
      vel_vld_r   <= vel_vld_nxt;
      ctl_vld_r   <= ctl_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    num_r      <= num_nxt;
    ok_r       <= ok_nxt;
    slot_ok_r  <= slot_ok_nxt;
    rd_r       <= rd_nxt;
    out_rd_r   <= out_rd_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_flag_r <= out_flag_nxt;
    out_bend_r <= out_bend_nxt;
  end

  always_ff @(posedge clk) begin
    if (vel_we) begin
      vel_mem[in_number[KEY_W-1:0]] <= sat7(in_value);
    end
    vel_q <= vel_mem[in_number[KEY_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl_we) begin
      ctl_mem[in_number[KEY_W-1:0]] <= sat7(in_value);
    end
    ctl_q <= ctl_mem[in_number[KEY_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (held_we) begin
      held_mem[held_wa] <= held_wd;
    end
    held_q <= held_mem[held_ra];
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_rd_r;
  assign out_held_count    = out_cnt_r;
  assign out_any_note_flag = out_flag_r;
  assign out_bend_offset   = signed'(out_bend_r);

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LIST_DEPTH))
    else $error("held list count beyond depth");

  a_search_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH || state_r == ST_SHIFT) |-> idx_r <= count_r)
    else $error("list walk ran past the fill count");

  a_shift_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && state_nxt == ST_DONE) |=>
      count_r == $past(count_r) - CW'(1))
    else $error("note removal did not shorten the list by one");

  a_list_write: assert property (@(posedge clk) disable iff (!rst_n)
    held_we |-> (state_r == ST_SEARCH || state_r == ST_SHIFT))
    else $error("held list written outside a list walk");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised without a finished transaction");
`endif

endmodule

FILE: tb/sv/midi_event_checker.sv
`timescale 1ns / 1ps

module midi_event_checker #(
  parameter int unsigned LIST_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [3:0]         in_cmd,
  input  logic [7:0]         in_number,
  input  logic [13:0]        in_value,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [6:0]         out_read_value,
  input  logic [7:0]         out_held_count,
  input  logic               out_any_note_flag,
  input  logic signed [13:0] out_bend_offset,
  output int                 fail_count,
  output int                 outstanding
);
  import mest_pkg::*;

  typedef struct packed {
    logic [6:0]  read_value;
    logic [7:0]  held_count;
    logic        any_note_flag;
    logic [13:0] bend_offset;
  } tracker_result_t;

  localparam int unsigned HELD_CAP = (LIST_DEPTH > TABLE_SIZE) ? TABLE_SIZE : LIST_DEPTH;

  logic [6:0]      velocity_tbl [TABLE_SIZE];
  logic [6:0]      ctrl_tbl     [TABLE_SIZE];
  logic [6:0]      held_notes   [TABLE_SIZE];
  int unsigned     held_total;
  logic [13:0]     bend_reg;
  logic            note_seen;
  tracker_result_t pending_results [$];
  int              fail_total;
  int              report_count;

  function automatic logic [6:0] clip_level(input logic [13:0] level);
    return (level[13:7] != '0) ? MAX7 : level[6:0];
  endfunction

  function automatic void clear_tracker();
    for (int unsigned idx = 0; idx < TABLE_SIZE; idx++) begin
      velocity_tbl[idx] = '0;
      ctrl_tbl[idx]     = '0;
      held_notes[idx]   = '0;
    end
    held_total = 0;
    bend_reg   = '0;
    note_seen  = 1'b0;
  endfunction

  // updates the tracked state and returns the result the event should give
  function automatic tracker_result_t track_event(input logic [3:0] cmd,
                                                  input logic [7:0] num,
                                                  input logic [13:0] val);
    tracker_result_t res;
    logic            in_range = (num < TABLE_SIZE);
    logic            found    = 1'b0;
    int              pos      = -1;
    logic [6:0]      rd       = '0;

    case (cmd)
      CMD_FRAME: note_seen = 1'b0;
      CMD_NOTE_ON: begin
        if (in_range) begin
          velocity_tbl[num[6:0]] = clip_level(val);
          note_seen = 1'b1;
          for (int unsigned slot = 0; slot < held_total; slot++)
            if (held_notes[slot] == num[6:0]) found = 1'b1;
          if (!found && held_total < HELD_CAP) begin
            held_notes[held_total] = num[6:0];
            held_total++;
          end
        end
      end
      CMD_NOTE_OFF: begin
        if (in_range) begin
          velocity_tbl[num[6:0]] = '0;
          for (int unsigned slot = 0; slot < held_total; slot++)
            if (pos < 0 && held_notes[slot] == num[6:0]) pos = slot;
          // close the gap left by the released note
          if (pos >= 0) begin
            for (int unsigned slot = pos; slot + 1 < held_total; slot++)
              held_notes[slot] = held_notes[slot + 1];
            held_total--;
          end
        end
      end
      CMD_CTRL:    if (in_range) ctrl_tbl[num[6:0]] = clip_level(val);
      CMD_BEND:    bend_reg = val - BEND_CENTER;
      CMD_RD_VEL:  if (in_range) rd = velocity_tbl[num[6:0]];
      CMD_RD_CTRL: if (in_range) rd = ctrl_tbl[num[6:0]];
      CMD_RD_SLOT: if (num < held_total) rd = held_notes[num[6:0]];
      CMD_CLEAR:   clear_tracker();
      default: ;
    endcase

    res.read_value    = rd;
    res.held_count    = held_total[7:0];
    res.any_note_flag = note_seen;
    res.bend_offset   = bend_reg;
    return res;
  endfunction

  always @(posedge clk) begin
    tracker_result_t want;
    tracker_result_t got;
    if (!rst_n) begin
      clear_tracker();
      pending_results.delete();
      fail_total   = 0;
      report_count = 0;
    end else begin
      // drain first: a result can never belong to an event taken at the same edge
      if (out_valid && out_ready) begin
        got = {out_read_value, out_held_count, out_any_note_flag, out_bend_offset};
        if (pending_results.size() == 0) begin
          fail_total++;
          if (report_count < 10) begin
            report_count++;
            $display("%0t: result transaction with no event outstanding", $time);
          end
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            fail_total++;
            if (report_count < 10) begin
              report_count++;
              $display("%0t: mismatch: expected read %0d count %0d flag %0b bend %0d,",
                       $time, want.read_value, want.held_count, want.any_note_flag,
                       $signed(want.bend_offset),
                       " got read %0d count %0d flag %0b bend %0d",
                       got.read_value, got.held_count, got.any_note_flag,
                       $signed(got.bend_offset));
            end
          end
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(track_event(in_cmd, in_number, in_value));
    end
    fail_count  <= fail_total;
    outstanding <= pending_results.size();
  end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import mest_pkg::*;

  localparam int unsigned LIST_DEPTH       = 128;
  localparam logic [3:0]  CMD_UNUSED_FIRST = 4'd9;
  localparam logic [3:0]  CMD_UNUSED_LAST  = 4'd15;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic [3:0]         in_cmd    = '0;
  logic [7:0]         in_number = '0;
  logic [13:0]        in_value  = '0;
  logic               out_ready = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic [6:0]         out_read_value;
  logic [7:0]         out_held_count;
  logic               out_any_note_flag;
  logic signed [13:0] out_bend_offset;
  int                 fail_count;
  int                 outstanding;
  int unsigned        gap_pct   = 0;
  int unsigned        stall_pct = 0;

  always #5 clk = ~clk;

  midi_event_state_tracker #(.LIST_DEPTH(LIST_DEPTH)) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_number         (in_number),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_value    (out_read_value),
    .out_held_count    (out_held_count),
    .out_any_note_flag (out_any_note_flag),
    .out_bend_offset   (out_bend_offset)
  );

  midi_event_checker #(.LIST_DEPTH(LIST_DEPTH)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_number         (in_number),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_value    (out_read_value),
    .out_held_count    (out_held_count),
    .out_any_note_flag (out_any_note_flag),
    .out_bend_offset   (out_bend_offset),
    .fail_count        (fail_count),
    .outstanding       (outstanding)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_event(input logic [3:0] cmd, input logic [7:0] num,
                            input logic [13:0] val);
    int gap = 0;
    while (gap < 24 && $urandom_range(0, 99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_number <= num;
    in_value  <= val;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // notes bunch up in the low range so that note-offs often hit held notes
  function automatic logic [7:0] pick_note();
    int unsigned r = $urandom_range(0, 99);
    if (r < 45) return 8'($urandom_range(0, 31));
    if (r < 88) return 8'($urandom_range(0, 127));
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic logic [7:0] pick_slot();
    int unsigned r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(0, 15));
    if (r < 85) return 8'($urandom_range(0, 127));
    return 8'($urandom_range(128, 255));
  endfunction

  function automatic logic [13:0] pick_level();
    int unsigned r = $urandom_range(0, 99);
    if (r < 15) return 14'd0;
    if (r < 30) return 14'd127;
    if (r < 45) return 14'd128;
    if (r < 65) return 14'($urandom_range(0, 127));
    return 14'($urandom_range(0, 16383));
  endfunction

  function automatic logic [13:0] pick_bend();
    int unsigned r = $urandom_range(0, 99);
    if (r < 10) return 14'd0;
    if (r < 20) return 14'd16383;
    if (r < 30) return BEND_CENTER;
    return 14'($urandom_range(0, 16383));
  endfunction

  task automatic random_event();
    int unsigned r = $urandom_range(0, 99);
    if (r < 28)       send_event(CMD_NOTE_ON, pick_note(), pick_level());
    else if (r < 46)  send_event(CMD_NOTE_OFF, pick_note(), 14'($urandom_range(0, 16383)));
    else if (r < 56)  send_event(CMD_CTRL, pick_note(), pick_level());
    else if (r < 64)  send_event(CMD_BEND, 8'($urandom_range(0, 255)), pick_bend());
    else if (r < 72)  send_event(CMD_RD_VEL, pick_note(), 14'($urandom_range(0, 16383)));
    else if (r < 78)  send_event(CMD_RD_CTRL, pick_note(), 14'($urandom_range(0, 16383)));
    else if (r < 90)  send_event(CMD_RD_SLOT, pick_slot(), 14'($urandom_range(0, 16383)));
    else if (r < 95)  send_event(CMD_FRAME, 8'($urandom_range(0, 255)),
                                 14'($urandom_range(0, 16383)));
    else if (r < 96)  send_event(CMD_CLEAR, 8'($urandom_range(0, 255)),
                                 14'($urandom_range(0, 16383)));
    else              send_event(4'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                                 8'($urandom_range(0, 255)), 14'($urandom_range(0, 16383)));
  endtask

  // hold every note in shuffled order, so the list reaches its full depth
  task automatic fill_all_notes();
    logic [7:0] order [TABLE_SIZE];
    logic [7:0] swap;
    int unsigned pick;
    for (int unsigned idx = 0; idx < TABLE_SIZE; idx++) order[idx] = 8'(idx);
    for (int unsigned idx = TABLE_SIZE - 1; idx > 0; idx--) begin
      pick        = $urandom_range(0, idx);
      swap        = order[idx];
      order[idx]  = order[pick];
      order[pick] = swap;
    end
    for (int unsigned idx = 0; idx < TABLE_SIZE; idx++)
      send_event(CMD_NOTE_ON, order[idx], pick_level());
    send_event(CMD_RD_SLOT, 8'd0, 14'd0);
    send_event(CMD_RD_SLOT, 8'd127, 14'd0);
    send_event(CMD_RD_SLOT, 8'd128, 14'd0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hand-picked corner cases on a fresh block
    send_event(CMD_RD_VEL, 8'd0, 14'd0);
    send_event(CMD_NOTE_ON, 8'd60, 14'd100);
    send_event(CMD_NOTE_ON, 8'd60, 14'd16383);
    send_event(CMD_NOTE_ON, 8'd127, 14'd0);
    send_event(CMD_NOTE_ON, 8'd0, 14'd127);
    send_event(CMD_NOTE_ON, 8'd200, 14'd50);
    send_event(CMD_RD_VEL, 8'd200, 14'd0);
    send_event(CMD_RD_VEL, 8'd60, 14'd0);
    send_event(CMD_RD_SLOT, 8'd0, 14'd0);
    send_event(CMD_RD_SLOT, 8'd2, 14'd0);
    send_event(CMD_RD_SLOT, 8'd3, 14'd0);
    send_event(CMD_RD_SLOT, 8'd255, 14'd16383);
    send_event(CMD_NOTE_OFF, 8'd60, 14'd0);
    send_event(CMD_NOTE_OFF, 8'd5, 14'd0);
    send_event(CMD_NOTE_OFF, 8'd255, 14'd0);
    send_event(CMD_CTRL, 8'd7, 14'd128);
    send_event(CMD_CTRL, 8'd255, 14'd1);
    send_event(CMD_RD_CTRL, 8'd7, 14'd0);
    send_event(CMD_RD_CTRL, 8'd255, 14'd0);
    send_event(CMD_BEND, 8'd0, 14'd0);
    send_event(CMD_BEND, 8'd255, 14'd16383);
    send_event(CMD_BEND, 8'd1, BEND_CENTER);
    send_event(CMD_FRAME, 8'd0, 14'd0);
    send_event(CMD_UNUSED_LAST, 8'd255, 14'd16383);
    send_event(CMD_CLEAR, 8'd0, 14'd0);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin gap_pct = 0;  stall_pct <= 0;  end
        1:       begin gap_pct = 66; stall_pct <= 0;  end
        2:       begin gap_pct = 0;  stall_pct <= 66; end
        default: begin gap_pct = 13; stall_pct <= 13; end
      endcase
      if (phase % 2 == 0) begin
        fill_all_notes();
        repeat (60) random_event();
      end else begin
        repeat (190) random_event();
      end
      wait_drained();
    end

    repeat (300) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
sv/mest_pkg.sv
sv/midi_event_state_tracker.sv
tb/sv/midi_event_checker.sv
tb/sv/tb_top.sv
